[hdl/las_pkg.sv]
// ----------------------------------------------------------------------------
// las_pkg: shared types and constants for the local alignment score block
// Widths, request codes, channel structs and the token that walks the cells.
// ----------------------------------------------------------------------------
package las_pkg;

  localparam int MAX_QUERY  = 256;
  localparam int ALPHABET   = 26;
  localparam int SCORE_BITS = 16;

  localparam int QADDR_W     = $clog2(MAX_QUERY);
  localparam int QCNT_W      = $clog2(MAX_QUERY + 1);
  localparam int LET_W       = 5;
  localparam int GAP_W       = 7;
  localparam int TSCORE_W    = 8;
  localparam int TBL_IDX_W   = 10;
  localparam int TBL_ENTRIES = ALPHABET * ALPHABET;
  // Two guard bits cover a score plus a signed table entry or gap.
  localparam int CALC_W      = SCORE_BITS + 2;

  localparam logic [1:0] REQ_TABLE  = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_TARGET = 2'd2;

  localparam logic signed [GAP_W-1:0] GAP_RESET = -GAP_W'(4);

  typedef struct packed {
    logic [1:0]                  req_type;
    logic [TBL_IDX_W-1:0]        table_index;
    logic signed [TSCORE_W-1:0]  table_score;
    logic [LET_W-1:0]            residue;
    logic                        last_residue;
  } las_in_t;

  typedef struct packed {
    logic [SCORE_BITS-1:0] best_score;
    logic                  score_saturated;
  } las_out_t;

  // One row of the substitution table: all query letters for one target letter.
  typedef logic [ALPHABET-1:0][TSCORE_W-1:0] las_row_t;

  // Wavefront token handed from cell to cell.
  typedef struct packed {
    logic                  vld;
    logic [SCORE_BITS-1:0] up;
    logic [SCORE_BITS-1:0] diag;
    logic [SCORE_BITS-1:0] best;
    logic                  sat;
  } las_tok_t;

  typedef struct packed {
    logic act;
    logic q_we;
    logic clr;
  } las_cell_ctl_t;

endpackage

[hdl/las_table.sv]
// ----------------------------------------------------------------------------
// las_table: substitution score memory
// Stored as one row per target letter so a whole row comes out of one read;
// a table load writes a single lane of one row.
// ----------------------------------------------------------------------------
module las_table (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [las_pkg::TBL_IDX_W-1:0]       wr_index,
  input  logic signed [las_pkg::TSCORE_W-1:0] wr_score,
  input  logic                                rd_en,
  input  logic [las_pkg::LET_W-1:0]           rd_letter,
  output las_pkg::las_row_t                   rd_row
);
  import las_pkg::*;

  localparam int RECIP_SHIFT = TBL_IDX_W + 3;
  localparam int RECIP       = (1 << RECIP_SHIFT) / ALPHABET;
  localparam int PROD_W      = 2 * TBL_IDX_W + 3;

  las_row_t tbl_mem [ALPHABET];
  las_row_t rd_row_r;

  logic [PROD_W-1:0]    prod;
  logic [TBL_IDX_W-1:0] quo_est;
  logic [TBL_IDX_W-1:0] rem_est;
  logic [TBL_IDX_W-1:0] quo;
  logic [TBL_IDX_W-1:0] rem;
  logic                 idx_ok;

  // index / ALPHABET by a reciprocal that never overestimates, then one fixup.
  always_comb begin
    prod    = PROD_W'(wr_index) * PROD_W'(RECIP);
    quo_est = TBL_IDX_W'(prod >> RECIP_SHIFT);
    rem_est = wr_index - TBL_IDX_W'(quo_est * TBL_IDX_W'(ALPHABET));
    if (rem_est >= TBL_IDX_W'(ALPHABET)) begin
      quo = quo_est + TBL_IDX_W'(1);
      rem = rem_est - TBL_IDX_W'(ALPHABET);
    end else begin
      quo = quo_est;
      rem = rem_est;
    end
    idx_ok = wr_index < TBL_IDX_W'(TBL_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (wr_en && idx_ok) begin
      tbl_mem[rem[LET_W-1:0]][quo[LET_W-1:0]] <= wr_score;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_letter < LET_W'(ALPHABET)) begin
        rd_row_r <= tbl_mem[rd_letter];
      end else begin
        rd_row_r <= '0;
      end
    end
  end

  assign rd_row = rd_row_r;

endmodule

[hdl/las_cell.sv]
// ----------------------------------------------------------------------------
// las_cell: one query position of the alignment column
// Holds the query letter and the previous column score for its row, updates
// the score when the token passes and hands the token to the next cell.
// ----------------------------------------------------------------------------
module las_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  las_pkg::las_cell_ctl_t            ctl,
  input  logic [las_pkg::LET_W-1:0]         q_data,
  input  las_pkg::las_row_t                 row,
  input  logic signed [las_pkg::GAP_W-1:0]  gap,
  input  las_pkg::las_tok_t                 tok_in,
  output las_pkg::las_tok_t                 tok_out
);
  import las_pkg::*;

  localparam logic signed [CALC_W-1:0] CAP = CALC_W'((1 << SCORE_BITS) - 1);

  logic [LET_W-1:0]            q_r;
  logic [SCORE_BITS-1:0]       col_r;
  logic [SCORE_BITS-1:0]       col_nxt;
  las_tok_t                    tok_r;
  las_tok_t                    tok_nxt;

  logic signed [TSCORE_W-1:0]  sub;
  logic signed [CALC_W-1:0]    s_diag;
  logic signed [CALC_W-1:0]    s_up;
  logic signed [CALC_W-1:0]    s_left;
  logic signed [CALC_W-1:0]    s_max;
  logic [SCORE_BITS-1:0]       cval;
  logic                        clip;
  logic                        upd;

  always_comb begin
    sub    = (q_r < LET_W'(ALPHABET)) ? $signed(row[q_r]) : '0;
    s_diag = $signed({2'b00, tok_in.diag}) + CALC_W'(sub);
    s_up   = $signed({2'b00, tok_in.up}) + CALC_W'(gap);
    s_left = $signed({2'b00, col_r}) + CALC_W'(gap);
    s_max  = s_diag;
    if (s_up > s_max) begin
      s_max = s_up;
    end
    if (s_left > s_max) begin
      s_max = s_left;
    end
    clip = 1'b0;
    if (s_max < 0) begin
      cval = '0;
    end else if (s_max > CAP) begin
      cval = '1;
      clip = 1'b1;
    end else begin
      cval = s_max[SCORE_BITS-1:0];
    end

    upd     = tok_in.vld && ctl.act;
    tok_nxt = tok_in;
    col_nxt = col_r;
    if (upd) begin
      tok_nxt.up   = cval;
      tok_nxt.diag = col_r;
      tok_nxt.best = (cval > tok_in.best) ? cval : tok_in.best;
      tok_nxt.sat  = tok_in.sat | clip;
      col_nxt      = cval;
    end
    if (ctl.clr) begin
      col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      tok_r <= '0;
    end else begin
      col_r <= col_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.q_we) begin
      q_r <= q_data;
    end
  end

  assign tok_out = tok_r;

endmodule

[hdl/local_alignment_score.sv]
// ----------------------------------------------------------------------------
// local_alignment_score: Smith-Waterman local alignment score, linear gap
// Every request keeps in_stall high until the block is idle again. A target
// residue's token walks the row of MAX_QUERY cells one cell per cycle, so the
// cell chain length sets how long a target residue takes. A last target
// residue then waits until the output is free to present the result.
// Synchronous reset clears control, column scores and best score and sets
// gap_r to -4; table and query letters stay undefined until loaded.
// ----------------------------------------------------------------------------
module local_alignment_score (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  las_pkg::las_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output las_pkg::las_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic signed [las_pkg::GAP_W-1:0]   cfg_wdata
);
  import las_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_INJECT = 3'd2;
  localparam logic [2:0] ST_RUN    = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]               state_r, state_nxt;
  las_in_t                  item_r;
  logic signed [GAP_W-1:0]  gap_r;
  logic [QCNT_W-1:0]        fill_r, fill_nxt;
  logic [QCNT_W-1:0]        count_r, count_nxt;
  logic [SCORE_BITS-1:0]    best_r, best_nxt;
  logic                     sat_r, sat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  las_out_t                 out_data_r;

  logic                     in_acc;
  logic                     out_free;
  logic                     q_wr;
  logic                     col_clr;
  logic                     tbl_wr;
  logic                     tbl_rd;
  logic                     load_out;
  las_row_t                 row;
  las_tok_t                 tok_chain [MAX_QUERY+1];
  logic [MAX_QUERY-1:0]     tok_vld_vec;
  las_tok_t                 tok_end;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign tok_end  = tok_chain[MAX_QUERY];

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    best_nxt      = best_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_wr          = 1'b0;
    col_clr       = 1'b0;
    tbl_wr        = 1'b0;
    tbl_rd        = 1'b0;
    load_out      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (item_r.req_type)
          REQ_TABLE: begin
            tbl_wr = 1'b1;
          end
          REQ_QUERY: begin
            q_wr = fill_r < QCNT_W'(MAX_QUERY);
            if (q_wr) begin
              fill_nxt = fill_r + QCNT_W'(1);
            end
            // The last query letter fixes the length and starts a fresh column.
            if (item_r.last_residue) begin
              count_nxt = fill_nxt;
              fill_nxt  = '0;
              col_clr   = 1'b1;
              best_nxt  = '0;
              sat_nxt   = 1'b0;
            end
          end
          REQ_TARGET: begin
            tbl_rd    = 1'b1;
            state_nxt = ST_INJECT;
          end
          default: begin
          end
        endcase
      end
      ST_INJECT: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (tok_end.vld) begin
          best_nxt  = tok_end.best;
          sat_nxt   = tok_end.sat;
          state_nxt = item_r.last_residue ? ST_RESULT : ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          col_clr       = 1'b1;
          best_nxt      = '0;
          sat_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gap_r       <= GAP_RESET;
      fill_r      <= '0;
      count_r     <= '0;
      best_r      <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      best_r      <= best_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        gap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if (load_out) begin
      out_data_r.best_score      <= best_r;
      out_data_r.score_saturated <= sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  las_table u_table (
    .clk       (clk),
    .wr_en     (tbl_wr),
    .wr_index  (item_r.table_index),
    .wr_score  (item_r.table_score),
    .rd_en     (tbl_rd),
    .rd_letter (item_r.residue),
    .rd_row    (row)
  );

  // Row 0 of the matrix is zero, so the token enters with zero up and diag.
  assign tok_chain[0] = '{vld: (state_r == ST_INJECT), up: '0, diag: '0,
                          best: best_r, sat: sat_r};

  for (genvar i = 0; i < MAX_QUERY; i++) begin : g_cell
    las_cell_ctl_t ctl;

    always_comb begin
      ctl.act  = QCNT_W'(i) < count_r;
      ctl.q_we = q_wr && (fill_r[QADDR_W-1:0] == QADDR_W'(i));
      ctl.clr  = col_clr;
    end

    las_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .q_data  (item_r.residue),
      .row     (row),
      .gap     (gap_r),
      .tok_in  (tok_chain[i]),
      .tok_out (tok_chain[i+1])
    );

    assign tok_vld_vec[i] = tok_chain[i+1].vld;
  end

  // Only one target residue is in the chain at any time.
  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld_vec))
    else $error("more than one token in the cell chain");

  a_exit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.vld |-> (state_r == ST_RUN))
    else $error("token left the chain outside a target run");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && out_free) |=> (out_valid && state_r == ST_IDLE))
    else $error("pending result was not presented");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= QCNT_W'(MAX_QUERY)) && (count_r <= QCNT_W'(MAX_QUERY)))
    else $error("query length beyond the cell count");

endmodule

[dv/local_alignment_score_tb.sv]
// ----------------------------------------------------------------------------
// local_alignment_score_tb: self-checking bench for the alignment score block
// Streams table, query and target transactions with random idles on both
// sides, scores every column in a scoreboard model and checks each reported
// best score and saturation flag in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module local_alignment_score_tb;
  import las_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SCORE_CAP = (1 << SCORE_BITS) - 1;
  localparam int SETTLE_CYCLES = MAX_QUERY + 40;
  localparam int RUN_LIMIT_CYCLES = 3_000_000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  las_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  las_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic signed [GAP_W-1:0] cfg_wdata = '0;

  // Scoreboard copy of the block state.
  logic signed [TSCORE_W-1:0] subst_scores [TBL_ENTRIES];
  logic [LET_W-1:0] query_letters [MAX_QUERY];
  int       query_len = 0;
  int       query_fill = 0;
  int       col_scores [MAX_QUERY];
  int       best_run = 0;
  bit       clip_seen = 1'b0;
  int       gap_now = -4;
  las_out_t pending_best [$];
  las_out_t want_best;

  las_in_t  feed_q [$];
  bit       in_fire = 1'b0;
  bit       tx_idles = 1'b1;
  bit       rx_idles = 1'b1;
  int       rx_hold = 0;
  int       mismatch_count = 0;

  local_alignment_score u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic void log_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic void clear_column();
    for (int i = 0; i < MAX_QUERY; i++) col_scores[i] = 0;
    best_run = 0;
    clip_seen = 1'b0;
  endfunction

  // Applies one accepted transaction to the model and queues any result.
  task automatic apply_item(input las_in_t it);
    int diag, up, left, c, s;
    las_out_t done;
    case (it.req_type)
      REQ_TABLE: begin
        if (it.table_index < TBL_ENTRIES) subst_scores[it.table_index] = it.table_score;
      end
      REQ_QUERY: begin
        if (query_fill < MAX_QUERY) begin
          query_letters[query_fill] = it.residue;
          query_fill++;
        end
        if (it.last_residue) begin
          query_len = query_fill;
          query_fill = 0;
          clear_column();
        end
      end
      REQ_TARGET: begin
        diag = 0;
        up = 0;
        for (int i = 0; i < query_len; i++) begin
          left = col_scores[i];
          s = 0;
          if (query_letters[i] < ALPHABET && it.residue < ALPHABET)
            s = subst_scores[int'(query_letters[i]) * ALPHABET + int'(it.residue)];
          c = diag + s;
          if (up + gap_now > c) c = up + gap_now;
          if (left + gap_now > c) c = left + gap_now;
          if (c < 0) c = 0;
          if (c > SCORE_CAP) begin
            c = SCORE_CAP;
            clip_seen = 1'b1;
          end
          if (c > best_run) best_run = c;
          diag = left;
          up = c;
          col_scores[i] = c;
        end
        if (it.last_residue) begin
          done.best_score = best_run[SCORE_BITS-1:0];
          done.score_saturated = clip_seen;
          pending_best.push_back(done);
          clear_column();
        end
      end
      default: ;
    endcase
  endtask

  // Input and output transactions are both sampled here at the rising edge.
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_best.size() == 0) begin
        log_error($sformatf("result with nothing expected: best %0d sat %0b",
                            out_data.best_score, out_data.score_saturated));
      end else begin
        want_best = pending_best.pop_front();
        if (out_data.best_score !== want_best.best_score)
          log_error($sformatf("best_score expected %0d, got %0d",
                              want_best.best_score, out_data.best_score));
        if (out_data.score_saturated !== want_best.score_saturated)
          log_error($sformatf("score_saturated expected %0b, got %0b",
                              want_best.score_saturated, out_data.score_saturated));
      end
    end
    if (in_fire) apply_item(in_data);
  end

  // Sender: a stalled transaction holds; otherwise the next one may be idled.
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (feed_q.size() > 0 && !(tx_idles && $urandom_range(99) < 16)) begin
        in_data <= feed_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= rx_idles && ($urandom_range(99) < 16);
    end
  end

  initial begin
    repeat (RUN_LIMIT_CYCLES) @(posedge clk);
    $display("local_alignment_score_tb NOT OK");
    $finish;
  end

  function automatic las_in_t item_of(logic [1:0] req, logic [LET_W-1:0] letter, logic last);
    las_in_t it;
    it.req_type = req;
    it.table_index = TBL_IDX_W'($urandom);
    it.table_score = TSCORE_W'($urandom);
    it.residue = letter;
    it.last_residue = last;
    return it;
  endfunction

  function automatic logic [LET_W-1:0] rand_letter();
    if ($urandom_range(9) == 0) return LET_W'($urandom_range(31, ALPHABET));
    return LET_W'($urandom_range(ALPHABET - 1));
  endfunction

  task automatic send_item(input las_in_t it);
    while (feed_q.size() >= 2) @(posedge clk);
    feed_q.push_back(it);
  endtask

  task automatic write_entry(input logic [TBL_IDX_W-1:0] idx,
                             input logic signed [TSCORE_W-1:0] score);
    las_in_t it;
    it = item_of(REQ_TABLE, LET_W'($urandom), 1'($urandom));
    it.table_index = idx;
    it.table_score = score;
    send_item(it);
  endtask

  task automatic wait_drained();
    while (feed_q.size() != 0 || in_valid || pending_best.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_gap(input int g);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= GAP_W'(g);
    gap_now = g;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // No query loaded yet, so no table entry is used.
  task automatic test_empty_query();
    send_item(item_of(REQ_TARGET, 5'd0, 1'b0));
    send_item(item_of(REQ_TARGET, 5'd31, 1'b1));
    send_item(item_of(REQ_UNUSED, 5'd31, 1'b1));
    send_item(item_of(REQ_TARGET, 5'd25, 1'b1));
  endtask

  task automatic test_table_load();
    for (int idx = 0; idx < TBL_ENTRIES; idx++) begin
      if (idx == 0) write_entry(TBL_IDX_W'(idx), -8'sd128);
      else if (idx == TBL_ENTRIES - 1) write_entry(TBL_IDX_W'(idx), 8'sd127);
      else write_entry(TBL_IDX_W'(idx), TSCORE_W'($urandom));
    end
    // Indexes past the table are dropped.
    write_entry(TBL_IDX_W'(TBL_ENTRIES), TSCORE_W'($urandom));
    write_entry('1, TSCORE_W'($urandom));
  endtask

  task automatic test_directed();
    send_item(item_of(REQ_QUERY, 5'd0, 1'b0));
    send_item(item_of(REQ_QUERY, 5'd25, 1'b0));
    send_item(item_of(REQ_QUERY, 5'd26, 1'b0));
    send_item(item_of(REQ_QUERY, 5'd31, 1'b0));
    send_item(item_of(REQ_QUERY, 5'd7, 1'b1));
    send_item(item_of(REQ_TARGET, 5'd25, 1'b0));
    send_item(item_of(REQ_TARGET, 5'd0, 1'b0));
    send_item(item_of(REQ_TARGET, 5'd30, 1'b0));
    send_item(item_of(REQ_TARGET, 5'd7, 1'b1));
    set_gap(0);
    send_item(item_of(REQ_TARGET, 5'd31, 1'b0));
    send_item(item_of(REQ_TARGET, 5'd12, 1'b1));
    set_gap(-64);
    send_item(item_of(REQ_TARGET, 5'd0, 1'b0));
    send_item(item_of(REQ_TARGET, 5'd25, 1'b1));
    // Query letters rewritten while a target is still open.
    send_item(item_of(REQ_TARGET, 5'd4, 1'b0));
    send_item(item_of(REQ_QUERY, 5'd1, 1'b0));
    send_item(item_of(REQ_QUERY, 5'd2, 1'b0));
    send_item(item_of(REQ_TARGET, 5'd9, 1'b1));
    send_item(item_of(REQ_QUERY, 5'd3, 1'b1));
    send_item(item_of(REQ_TARGET, 5'd25, 1'b1));
    send_item(item_of(REQ_QUERY, 5'd0, 1'b1));
    send_item(item_of(REQ_TARGET, 5'd0, 1'b1));
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    set_gap(-2);
    for (int k = 0; k < 8; k++)
      send_item(item_of(REQ_QUERY, LET_W'($urandom_range(ALPHABET - 1)), k == 7));
    rx_hold = 3000;
    for (int k = 0; k < 16; k++) send_item(item_of(REQ_TARGET, rand_letter(), 1'b1));
    wait_drained();
  endtask

  task automatic test_random();
    int sent, len, pick;
    las_in_t it;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_gap(int'($urandom_range(64)) - 64);
        1: set_gap(int'($urandom_range(127)) - 64);
        2: set_gap(int'($urandom_range(64)) - 64);
        default: set_gap(int'($urandom_range(16)) - 16);
      endcase
      // Phase 2 runs with no idling on either side.
      tx_idles = (phase != 2);
      rx_idles = (phase != 2);
      sent = 0;
      if (phase == 1) begin
        len = $urandom_range(270, 250);
        for (int k = 0; k < len; k++) send_item(item_of(REQ_QUERY, rand_letter(), k == len - 1));
      end
      while (sent < 100) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          len = $urandom_range(24, 1);
          for (int k = 0; k < len; k++)
            send_item(item_of(REQ_QUERY, rand_letter(), k == len - 1));
          sent += len;
        end else if (pick < 80) begin
          len = $urandom_range(8, 1);
          for (int k = 0; k < len; k++)
            send_item(item_of(REQ_TARGET, rand_letter(), k == len - 1));
          sent += len;
        end else if (pick < 88) begin
          it = item_of(REQ_TABLE, LET_W'($urandom), 1'($urandom));
          send_item(it);
          if (it.table_index < TBL_ENTRIES) sent++;
        end else if (pick < 94) begin
          len = $urandom_range(3, 1);
          for (int k = 0; k < len; k++) send_item(item_of(REQ_QUERY, rand_letter(), 1'b0));
          sent += len;
        end else if (pick < 97) begin
          send_item(item_of(REQ_UNUSED, LET_W'($urandom), 1'($urandom)));
        end else begin
          len = $urandom_range(3, 1);
          for (int k = 0; k < len; k++) send_item(item_of(REQ_TARGET, rand_letter(), 1'b0));
          sent += len;
        end
      end
    end
    tx_idles = 1'b1;
    rx_idles = 1'b1;
  endtask

  // A full-length query of matching letters with a positive gap drives the
  // cells past the 16-bit ceiling; the extra query letters are dropped.
  task automatic test_saturation();
    set_gap(63);
    write_entry('0, 8'sd127);
    for (int k = 0; k < MAX_QUERY + 4; k++)
      send_item(item_of(REQ_QUERY, 5'd0, k == MAX_QUERY + 3));
    for (int k = 0; k < 800; k++) send_item(item_of(REQ_TARGET, 5'd0, k == 799));
    send_item(item_of(REQ_TARGET, 5'd0, 1'b1));
  endtask

  initial begin
    for (int i = 0; i < MAX_QUERY; i++) col_scores[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_query();
    test_table_load();
    test_directed();
    test_backpressure();
    test_random();
    test_saturation();
    wait_drained();
    if (mismatch_count == 0 && pending_best.size() == 0) begin
      $display("local_alignment_score_tb OK");
    end else begin
      $display("local_alignment_score_tb NOT OK");
    end
    $finish;
  end

endmodule
